// ===== src/matrix_inverse_4x4_lu_top_assert.svh =====
// Assertion macros for the matrix inverse block
`ifndef MATRIX_INVERSE_4X4_LU_TOP_ASSERT_SVH
`define MATRIX_INVERSE_4X4_LU_TOP_ASSERT_SVH

// Implication checked on every rising clock edge while out of reset.
`define MI_ASSERT_IMPL(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition checked in the cycle after a trigger.
`define MI_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mi4_pkg.sv =====
package mi4_pkg;

    localparam int DataW = 32;
    localparam int FracB = 16;
    localparam int WideW = 2 * DataW + 2;

    localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] OneQ   = DataW'(64'd1 << FracB);

    typedef logic signed [DataW-1:0] data_t;
    typedef logic [DataW:0]          mag_t;

    // shared arithmetic operations
    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_DIV = 3'd1,
        OP_SUB = 3'd2,
        OP_KEY = 3'd3,
        OP_RCP = 3'd4
    } op_t;

    typedef struct packed {
        logic  start;
        op_t   op;
        data_t a;
        data_t b;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        data_t res;
    } alu_rsp_t;

    function automatic mag_t magof(input data_t v);
        logic [DataW:0] e;
        begin
            e = {v[DataW-1], v};
            magof = v[DataW-1] ? (~e + 1'b1) : e;
        end
    endfunction

    // Saturate sign/magnitude to the signed range.
    function automatic data_t satf(input logic neg, input logic [WideW-1:0] m);
        logic [WideW-1:0] lim;
        logic [DataW-1:0] lo;
        begin
            lim = neg ? WideW'({1'b0, MaxPos}) + 1'b1 : WideW'(MaxPos);
            lo  = (m > lim) ? lim[DataW-1:0] : m[DataW-1:0];
            satf = neg ? data_t'(~lo + 1'b1) : data_t'(lo);
        end
    endfunction

endpackage

// ===== src/matrix_inverse_4x4_lu_top.sv =====
// Sequence: 16 load beats, then the inversion as up to 160 ops on one shared
//   ALU (divide, multiply, subtract), then 16 result beats.
// Throughput: one matrix at a time; the input stalls after the 16th beat is taken
//   until the last result beat is taken. Rate is set by the single shared ALU/divider.
// Reset: rst_n asynchronous active low clears load count and control state;
//   matrix storage is not cleared.
module matrix_inverse_4x4_lu_top
    import mi4_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  data_t element_in,
    output logic  out_valid,
    input  logic  out_stall,
    output data_t element_out,
    output logic  singular,
    output logic  last_element
);

    `include "matrix_inverse_4x4_lu_top_assert.svh"

    typedef enum logic [2:0] {
        T_LOAD = 3'b001,
        T_WORK = 3'b010,
        T_OUT  = 3'b100
    } tst_t;

    tst_t       st_reg;
    logic [3:0] cnt_reg;      // load / output beat index
    data_t      mat_reg [16];
    logic       go_reg;

    alu_req_t req;
    alu_rsp_t rsp;
    logic     sdone, ssing;
    data_t    res [16];

    mi4_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    mi4_seq u_seq (
        .clk(clk), .rst_n(rst_n), .start(go_reg), .mat_in(mat_reg),
        .req(req), .rsp(rsp), .done(sdone), .sing(ssing), .res_out(res)
    );

    logic in_acc, out_acc;
    assign in_stall  = (st_reg != T_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (st_reg == T_OUT);
    assign out_acc   = out_valid && !out_stall;

    assign element_out  = res[cnt_reg];
    assign singular     = ssing;
    assign last_element = (cnt_reg == 4'd15);

    always_ff @(posedge clk)
    begin
        if (in_acc)
            mat_reg[cnt_reg] <= element_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= T_LOAD;
            cnt_reg <= '0;
            go_reg  <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            unique case (st_reg)
                T_LOAD:
                    if (in_acc)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 4'd15)
                        begin
                            go_reg <= 1'b1;
                            st_reg <= T_WORK;
                        end
                    end
                T_WORK:
                    if (sdone) st_reg <= T_OUT;
                T_OUT:
                    if (out_acc)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 4'd15) st_reg <= T_LOAD;
                    end
                default: st_reg <= T_LOAD;
            endcase
        end
    end

    `MI_ASSERT_IMPL(a_no_in_when_busy, out_valid, in_stall, "input taken during output")
    `MI_ASSERT_NEXT(a_done_to_out, sdone, out_valid, "finished inverse not presented")
    `MI_ASSERT_NEXT(a_last_wraps, out_acc && last_element, !out_valid,
                    "output continued past last beat")

endmodule

// ===== src/mi4_alu.sv =====
module mi4_alu
    import mi4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int QW = DataW + 2 * FracB + 1;
    localparam int CntW = $clog2(QW + 1);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_DONE = 4'b1000
    } ast_t;

    ast_t             st_reg, st_next;
    op_t              op_reg;
    logic             neg_reg;
    mag_t             am_reg, bm_reg;
    logic [WideW-1:0] prod_reg;
    logic [QW-1:0]    num_reg;
    logic [QW-1:0]    quo_reg;
    logic [DataW:0]   rem_reg;
    logic [CntW-1:0]  cnt_reg;
    data_t            res_reg;

    logic [DataW+1:0] rtry;
    logic [DataW+1:0] rsh;
    logic [WideW-1:0] shp;

    always_comb
    begin
        rsh  = {rem_reg, num_reg[QW-1]};
        rtry = rsh - {1'b0, bm_reg};
        shp  = prod_reg >> FracB;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            A_IDLE: if (req.start) st_next = (req.op == OP_DIV || req.op == OP_RCP) ? A_DIV
                                       : (req.op == OP_SUB) ? A_DONE : A_MUL;
            A_MUL:  st_next = A_DONE;
            A_DIV:  if (cnt_reg == '0) st_next = A_DONE;
            A_DONE: st_next = A_IDLE;
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= A_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            A_IDLE:
            begin
                op_reg  <= req.op;
                am_reg  <= magof(req.a);
                bm_reg  <= (req.op == OP_RCP) ? magof(req.a) : magof(req.b);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CntW'(QW - 1);
                if (req.op == OP_RCP)
                begin
                    neg_reg <= 1'b0;
                    num_reg <= QW'(1) << (2 * FracB);
                end
                else
                begin
                    num_reg <= QW'(magof(req.a)) << FracB;
                    neg_reg <= (req.op == OP_SUB) ? req.a[DataW-1]
                             : (req.a[DataW-1] ^ req.b[DataW-1]);
                end
                if (req.op == OP_SUB)
                begin
                    // a - b: add magnitudes when signs differ
                    if (req.a[DataW-1] != req.b[DataW-1] || magof(req.b) == '0)
                        res_reg <= satf(req.a[DataW-1],
                                        WideW'(magof(req.a) + magof(req.b)));
                    else if (magof(req.a) >= magof(req.b))
                        res_reg <= satf(req.a[DataW-1],
                                        WideW'(magof(req.a) - magof(req.b)));
                    else
                        res_reg <= satf(~req.b[DataW-1],
                                        WideW'(magof(req.b) - magof(req.a)));
                end
            end
            A_MUL:
            begin
                prod_reg <= WideW'(am_reg * bm_reg);
            end
            A_DIV:
            begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (rtry[DataW+1] == 1'b0)
                begin
                    rem_reg <= rtry[DataW:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rsh[DataW:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            A_DONE:
            begin
                unique case (op_reg)
                    OP_MUL: res_reg <= satf(neg_reg, shp);
                    OP_KEY: res_reg <= satf(1'b0, shp);
                    OP_DIV: res_reg <= (bm_reg == '0) ? '0 : satf(neg_reg, WideW'(quo_reg));
                    OP_RCP: res_reg <= satf(1'b0, WideW'(quo_reg));
                    OP_SUB: res_reg <= res_reg;
                    default: res_reg <= res_reg;
                endcase
            end
            default: ;
        endcase
    end

    // done pulses in the cycle after A_DONE, result valid then
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (st_reg == A_DONE);
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ===== src/mi4_seq.sv =====
module mi4_seq
    import mi4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  data_t    mat_in [16],
    output alu_req_t req,
    input  alu_rsp_t rsp,
    output logic     done,
    output logic     sing,
    output data_t    res_out [16]
);

    // Micro-step sequencer over the inversion.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCALE = 9'b000000010,
        S_PIV   = 9'b000000100,
        S_ELIMF = 9'b000001000,
        S_ELIMM = 9'b000010000,
        S_ELIMS = 9'b000100000,
        S_SUBM  = 9'b001000000,
        S_SUBS  = 9'b010000000,
        S_END   = 9'b100000000
    } sst_t;

    sst_t        st_reg;
    logic        busy_reg;           // an ALU op is in flight
    data_t       w_reg [16];
    data_t       sc_reg [4];
    logic [1:0]  ord_reg [4];
    data_t       x_reg [4];
    data_t       r_reg [16];
    logic [1:0]  j_reg, k_reg, i_reg, c_reg;
    logic        back_reg;           // back substitution phase
    logic [1:0]  best_reg;
    data_t       bk_reg, tmp_reg;
    logic        sing_reg, done_reg;

    logic [DataW:0] rmax [4];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            rmax[r] = magof(mat_in[r*4]);
            for (int q = 1; q < 4; q++)
                if (magof(mat_in[r*4+q]) > rmax[r])
                    rmax[r] = magof(mat_in[r*4+q]);
        end
    end

    logic [1:0] rj, rk, ri;
    assign rj = ord_reg[j_reg];
    assign rk = ord_reg[k_reg];
    assign ri = ord_reg[i_reg];

    function automatic data_t rd(input data_t m [16], input logic [1:0] r, input logic [1:0] c);
        rd = m[{r, c}];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            req.start <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            req.start <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (start)
                    begin
                        w_reg <= mat_in;
                        j_reg <= '0;
                        busy_reg <= 1'b0;
                        for (int r = 0; r < 4; r++)
                            ord_reg[r] <= 2'(r);
                        if (rmax[0] == '0 || rmax[1] == '0 || rmax[2] == '0 || rmax[3] == '0)
                        begin
                            sing_reg <= 1'b1;
                            st_reg <= S_END;
                        end
                        else
                        begin
                            sing_reg <= 1'b0;
                            st_reg <= S_SCALE;
                        end
                    end
                S_SCALE:
                    if (!busy_reg)
                    begin
                        req.start <= 1'b1; req.op <= OP_RCP;
                        req.a <= rmax[j_reg][DataW] ? data_t'({1'b1, {(DataW-1){1'b0}}})
                                                    : data_t'(rmax[j_reg][DataW-1:0]);
                        req.b <= '0;
                        busy_reg <= 1'b1;
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0;
                        sc_reg[j_reg] <= rsp.res;
                        if (j_reg == 2'd3)
                        begin
                            j_reg <= '0; k_reg <= '0; st_reg <= S_PIV;
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                S_PIV:
                    // key for row k_reg >= j_reg, column j_reg
                    if (!busy_reg)
                    begin
                        if (k_reg < j_reg) k_reg <= j_reg;
                        else
                        begin
                            req.start <= 1'b1; req.op <= OP_KEY;
                            req.a <= rd(w_reg, rk, j_reg);
                            req.b <= sc_reg[rk];
                            busy_reg <= 1'b1;
                        end
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0;
                        if (k_reg == j_reg || $unsigned(rsp.res) > $unsigned(bk_reg))
                        begin
                            bk_reg <= rsp.res; best_reg <= k_reg;
                        end
                        if (k_reg == 2'd3)
                        begin
                            logic [1:0] b;
                            b = (k_reg == j_reg || $unsigned(rsp.res) > $unsigned(bk_reg))
                                ? k_reg : best_reg;
                            if (b != j_reg)
                            begin
                                ord_reg[j_reg] <= ord_reg[b];
                                ord_reg[b] <= ord_reg[j_reg];
                            end
                            if (rd(w_reg, ord_reg[b], j_reg) == '0)
                            begin
                                sing_reg <= 1'b1; st_reg <= S_END;
                            end
                            else if (j_reg == 2'd3)
                            begin
                                // last column has only itself as candidate, no swap
                                c_reg <= '0; i_reg <= '0; back_reg <= 1'b0;
                                for (int r = 0; r < 4; r++)
                                    x_reg[r] <= (ord_reg[r] == 2'd0) ? data_t'(OneQ) : '0;
                                k_reg <= 2'd1;
                                st_reg <= S_SUBM;
                            end
                            else
                            begin
                                k_reg <= j_reg + 1'b1; st_reg <= S_ELIMF;
                            end
                        end
                        else k_reg <= k_reg + 1'b1;
                    end
                S_ELIMF:
                    if (!busy_reg)
                    begin
                        req.start <= 1'b1; req.op <= OP_DIV;
                        req.a <= rd(w_reg, rk, j_reg); req.b <= rd(w_reg, rj, j_reg);
                        busy_reg <= 1'b1;
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0;
                        w_reg[{rk, j_reg}] <= rsp.res;
                        i_reg <= j_reg + 1'b1;
                        st_reg <= S_ELIMM;
                    end
                S_ELIMM:
                    if (!busy_reg)
                    begin
                        req.start <= 1'b1; req.op <= OP_MUL;
                        req.a <= rd(w_reg, rj, i_reg); req.b <= rd(w_reg, rk, j_reg);
                        busy_reg <= 1'b1;
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0; tmp_reg <= rsp.res; st_reg <= S_ELIMS;
                    end
                S_ELIMS:
                    if (!busy_reg)
                    begin
                        req.start <= 1'b1; req.op <= OP_SUB;
                        req.a <= rd(w_reg, rk, i_reg); req.b <= tmp_reg;
                        busy_reg <= 1'b1;
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0;
                        w_reg[{rk, i_reg}] <= rsp.res;
                        if (i_reg == 2'd3)
                        begin
                            if (k_reg == 2'd3)
                            begin
                                j_reg <= j_reg + 1'b1; k_reg <= j_reg + 1'b1;
                                st_reg <= S_PIV;
                            end
                            else
                            begin
                                k_reg <= k_reg + 1'b1; st_reg <= S_ELIMF;
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1; st_reg <= S_ELIMM;
                        end
                    end
                S_SUBM:
                    // forward: x[k] -= x[i]*L[k][i], i<k  (k_reg target, i_reg source)
                    // back: x[i] -= U[i][k]*x[k] for k = i+1 up to 3, then x[i] /= U[i][i]
                    if (!busy_reg)
                    begin
                        req.start <= 1'b1; busy_reg <= 1'b1;
                        if (!back_reg)
                        begin
                            req.op <= OP_MUL; req.a <= x_reg[i_reg];
                            req.b <= rd(w_reg, rk, i_reg);
                        end
                        else if (k_reg == i_reg)
                        begin
                            req.op <= OP_DIV; req.a <= x_reg[i_reg];
                            req.b <= rd(w_reg, ri, i_reg);
                        end
                        else
                        begin
                            req.op <= OP_MUL; req.a <= rd(w_reg, ri, k_reg);
                            req.b <= x_reg[k_reg];
                        end
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0;
                        if (back_reg && k_reg == i_reg)
                        begin
                            if (i_reg == 2'd0)
                            begin
                                for (int r = 0; r < 4; r++)
                                    r_reg[{2'(r), c_reg}] <= (r == 0) ? rsp.res : x_reg[r];
                                if (c_reg == 2'd3) st_reg <= S_END;
                                else
                                begin
                                    c_reg <= c_reg + 1'b1; back_reg <= 1'b0;
                                    i_reg <= '0; k_reg <= 2'd1;
                                    for (int r = 0; r < 4; r++)
                                        x_reg[r] <= (ord_reg[r] == c_reg + 1'b1)
                                                    ? data_t'(OneQ) : '0;
                                end
                            end
                            else
                            begin
                                // next row up starts its sums at column i
                                x_reg[i_reg] <= rsp.res;
                                i_reg <= i_reg - 1'b1;
                                k_reg <= i_reg;
                            end
                        end
                        else
                        begin
                            tmp_reg <= rsp.res; st_reg <= S_SUBS;
                        end
                    end
                S_SUBS:
                    if (!busy_reg)
                    begin
                        req.start <= 1'b1; req.op <= OP_SUB; busy_reg <= 1'b1;
                        req.a <= back_reg ? x_reg[i_reg] : x_reg[k_reg];
                        req.b <= tmp_reg;
                    end
                    else if (rsp.done)
                    begin
                        busy_reg <= 1'b0; st_reg <= S_SUBM;
                        if (!back_reg)
                        begin
                            x_reg[k_reg] <= rsp.res;
                            if (i_reg == k_reg - 1'b1)
                            begin
                                if (k_reg == 2'd3)
                                begin
                                    back_reg <= 1'b1; i_reg <= 2'd3; k_reg <= 2'd3;
                                end
                                else
                                begin
                                    k_reg <= k_reg + 1'b1; i_reg <= '0;
                                end
                            end
                            else i_reg <= i_reg + 1'b1;
                        end
                        else
                        begin
                            x_reg[i_reg] <= rsp.res;
                            // walk k up from i+1 to 3, then divide
                            k_reg <= (k_reg == 2'd3) ? i_reg : k_reg + 1'b1;
                        end
                    end
                S_END:
                begin
                    done_reg <= 1'b1;
                    st_reg <= S_IDLE;
                    if (sing_reg)
                        for (int e = 0; e < 16; e++)
                            r_reg[e] <= (e % 5 == 0) ? data_t'(OneQ) : '0;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign sing = sing_reg;
    assign res_out = r_reg;

endmodule
